// File: hdl/htat_pkg.sv
// Shared types and constants for the host traffic accounting table.
// No dependencies; used by every module of the block.
`default_nettype none

package htat_pkg;

    localparam int IP_W              = 32;
    localparam int CNT_W             = 64;
    localparam int LANES             = 4;
    localparam int WORD_W            = CNT_W * LANES;
    localparam int IDX_W             = 8;
    localparam int CFG_IDX_W         = 3;
    localparam int CAT_W             = 2;
    localparam int SUBNETS_MAX       = 4;
    localparam int TABLE_ENTRIES_DEF = 256;
    localparam int LOCAL_SUBNETS_DEF = 4;

    // Request codes
    localparam logic REQ_RECORD = 1'b0;
    localparam logic REQ_READ   = 1'b1;

    // Counter lanes inside one counter word
    localparam logic [1:0] LANE_ACCT_PKT  = 2'd0;
    localparam logic [1:0] LANE_ACCT_BYTE = 2'd1;
    localparam logic [1:0] LANE_UNAC_PKT  = 2'd2;
    localparam logic [1:0] LANE_UNAC_BYTE = 2'd3;

    typedef enum logic [2:0] {
        CFG_NET_0  = 3'd0,
        CFG_NET_1  = 3'd1,
        CFG_NET_2  = 3'd2,
        CFG_NET_3  = 3'd3,
        CFG_MASK_0 = 3'd4,
        CFG_MASK_1 = 3'd5,
        CFG_MASK_2 = 3'd6,
        CFG_MASK_3 = 3'd7
    } cfg_reg_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CLASSIFY,
        ST_SCAN,
        ST_ADD,
        ST_WRITE,
        ST_READ,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic src_local;
        logic dst_local;
    } class_t;

    typedef struct packed {
        logic [1:0] lane;
        logic       fresh;
        logic       unacc;
    } add_ctl_t;

endpackage

`default_nettype wire

// File: hdl/htat_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Depends on htat_pkg for default sizes.
`default_nettype none

module htat_ram #(
    parameter int WIDTH = htat_pkg::IP_W,
    parameter int DEPTH = htat_pkg::TABLE_ENTRIES_DEF,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic             re,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// File: hdl/htat_subnet.sv
// Local subnet registers and the address classifier.
// Depends on htat_pkg (cfg_reg_t, class_t, widths).
`default_nettype none

module htat_subnet #(
    parameter int LOCAL_SUBNETS = htat_pkg::LOCAL_SUBNETS_DEF
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           cfg_we,
    input  wire logic [htat_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [htat_pkg::IP_W-1:0]      cfg_data,
    input  wire logic [htat_pkg::IP_W-1:0]      src_ip,
    input  wire logic [htat_pkg::IP_W-1:0]      dst_ip,
    output htat_pkg::class_t                    cls
);

    logic [htat_pkg::IP_W-1:0] net_reg  [htat_pkg::SUBNETS_MAX];
    logic [htat_pkg::IP_W-1:0] mask_reg [htat_pkg::SUBNETS_MAX];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < htat_pkg::SUBNETS_MAX; k++)
            begin
                net_reg[k]  <= '0;
                mask_reg[k] <= '1;
            end
        end
        else if (cfg_we)
        begin
            unique case (htat_pkg::cfg_reg_t'(cfg_index))
                htat_pkg::CFG_NET_0:  net_reg[0]  <= cfg_data;
                htat_pkg::CFG_NET_1:  net_reg[1]  <= cfg_data;
                htat_pkg::CFG_NET_2:  net_reg[2]  <= cfg_data;
                htat_pkg::CFG_NET_3:  net_reg[3]  <= cfg_data;
                htat_pkg::CFG_MASK_0: mask_reg[0] <= cfg_data;
                htat_pkg::CFG_MASK_1: mask_reg[1] <= cfg_data;
                htat_pkg::CFG_MASK_2: mask_reg[2] <= cfg_data;
                htat_pkg::CFG_MASK_3: mask_reg[3] <= cfg_data;
                default:              net_reg[0]  <= net_reg[0];
            endcase
        end
    end

    // Masked compare against each enabled subnet; any match marks local.
    always_comb
    begin
        cls = '0;
        for (int k = 0; k < LOCAL_SUBNETS; k++)
        begin
            if ((net_reg[k] & mask_reg[k]) == (src_ip & mask_reg[k]))
            begin
                cls.src_local = 1'b1;
            end
            if ((net_reg[k] & mask_reg[k]) == (dst_ip & mask_reg[k]))
            begin
                cls.dst_local = 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

// File: hdl/htat_adder.sv
// Shared 64-bit counter adder, used once per counter lane.
// Depends on htat_pkg (add_ctl_t, widths).
`default_nettype none

module htat_adder (
    input  wire logic [htat_pkg::WORD_W-1:0] old_word,
    input  htat_pkg::add_ctl_t               ctl,
    input  wire logic [htat_pkg::CNT_W-1:0]  flow_packets,
    input  wire logic [htat_pkg::CNT_W-1:0]  flow_bytes,
    output logic      [htat_pkg::CNT_W-1:0]  sum
);

    logic [htat_pkg::CNT_W-1:0] old_lane;
    logic [htat_pkg::CNT_W-1:0] delta;

    always_comb
    begin
        // A freshly appended entry starts from zero.
        old_lane = ctl.fresh ? '0 : old_word[ctl.lane * htat_pkg::CNT_W +: htat_pkg::CNT_W];
        // Upper lanes take local-to-local traffic, lower lanes accounted traffic.
        if (ctl.lane[1] == ctl.unacc)
        begin
            delta = ctl.lane[0] ? flow_bytes : flow_packets;
        end
        else
        begin
            delta = '0;
        end
        sum = old_lane + delta;
    end

endmodule

`default_nettype wire

// File: hdl/host_traffic_accounting_table_unit.sv
// Top level of the host traffic accounting table: sequencer, table memories,
// subnet classifier and shared adder. Depends on htat_pkg, htat_ram,
// htat_subnet and htat_adder.
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+---------------------------------------
//  cfg     | in        | cfg_we             | cfg_index, cfg_data
//  in      | in        | in_valid/in_stall  | req_type, src_ip, dst_ip, flow_packets,
//          |           |                    | flow_bytes, read_index
//  out     | out       | out_valid/out_stall| category, table_full, entry_valid,
//          |           |                    | entry_ip, entry_packets, entry_bytes,
//          |           |                    | entry_unacc_packets, entry_unacc_bytes
//
// A read transaction passes through the READ and DONE states. A record
// transaction goes from CLASSIFY to DONE when neither address is local, else
// each host update searches the filled entries, one table address compared
// per cycle on the address RAM read port, then makes the four lane adds
// through the one shared adder and the write-back; two local hosts run two updates.
// Reset empties the table at once through the fill count; no clearing pass.
// in_stall is high while a transaction is in work; a finished result waits in
// the output register under out_stall, and only the next completion waits for it.
`default_nettype none

module host_traffic_accounting_table_unit #(
    parameter int TABLE_ENTRIES = htat_pkg::TABLE_ENTRIES_DEF,
    parameter int LOCAL_SUBNETS = htat_pkg::LOCAL_SUBNETS_DEF
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           cfg_we,
    input  wire logic [htat_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [htat_pkg::IP_W-1:0]      cfg_data,
    input  wire logic                           in_valid,
    output logic                                in_stall,
    input  wire logic                           req_type,
    input  wire logic [htat_pkg::IP_W-1:0]      src_ip,
    input  wire logic [htat_pkg::IP_W-1:0]      dst_ip,
    input  wire logic [htat_pkg::CNT_W-1:0]     flow_packets,
    input  wire logic [htat_pkg::CNT_W-1:0]     flow_bytes,
    input  wire logic [htat_pkg::IDX_W-1:0]     read_index,
    output logic                                out_valid,
    input  wire logic                           out_stall,
    output logic      [htat_pkg::CAT_W-1:0]     category,
    output logic                                table_full,
    output logic                                entry_valid,
    output logic      [htat_pkg::IP_W-1:0]      entry_ip,
    output logic      [htat_pkg::CNT_W-1:0]     entry_packets,
    output logic      [htat_pkg::CNT_W-1:0]     entry_bytes,
    output logic      [htat_pkg::CNT_W-1:0]     entry_unacc_packets,
    output logic      [htat_pkg::CNT_W-1:0]     entry_unacc_bytes
);

    localparam int AW   = $clog2(TABLE_ENTRIES);
    localparam int CW   = $clog2(TABLE_ENTRIES + 1);
    localparam int CMPW = (CW > htat_pkg::IDX_W) ? CW : htat_pkg::IDX_W;
    localparam int IPW  = htat_pkg::IP_W;
    localparam int CTW  = htat_pkg::CNT_W;
    localparam int WW   = htat_pkg::WORD_W;

    // ---------------------------------------------------------------
    // State
    // ---------------------------------------------------------------
    htat_pkg::state_t state_reg, state_next;

    logic [CW-1:0]  fill_count_reg, fill_count_next;
    logic [CW-1:0]  scan_reg, scan_next;
    logic           pend_reg, pend_next;
    logic [AW-1:0]  pend_idx_reg, pend_idx_next;
    logic [AW-1:0]  target_reg, target_next;
    logic [IPW-1:0] key_reg, key_next;
    logic           fresh_reg, fresh_next;
    logic           unacc_reg, unacc_next;
    logic           second_reg, second_next;
    logic [1:0]     lane_reg, lane_next;
    logic           full_reg, full_next;
    logic [htat_pkg::CAT_W-1:0] cat_reg, cat_next;
    logic           entry_ok_reg, entry_ok_next;

    // Captured transaction payload
    logic                         req_reg;
    logic [IPW-1:0]               src_reg;
    logic [IPW-1:0]               dst_reg;
    logic [CTW-1:0]               pk_reg;
    logic [CTW-1:0]               by_reg;
    logic [htat_pkg::IDX_W-1:0]   idx_reg;

    // Lane sums of the entry being updated
    logic [CTW-1:0] sum_reg [htat_pkg::LANES];

    // Output register
    logic                         out_valid_reg, out_valid_next;
    logic [htat_pkg::CAT_W-1:0]   category_reg, category_next;
    logic                         table_full_reg, table_full_next;
    logic                         entry_valid_reg, entry_valid_next;
    logic [IPW-1:0]               entry_ip_reg, entry_ip_next;
    logic [CTW-1:0]               entry_pk_reg, entry_pk_next;
    logic [CTW-1:0]               entry_by_reg, entry_by_next;
    logic [CTW-1:0]               entry_upk_reg, entry_upk_next;
    logic [CTW-1:0]               entry_uby_reg, entry_uby_next;

    // Memory ports
    logic           host_we, host_re;
    logic [AW-1:0]  host_waddr, host_raddr;
    logic [IPW-1:0] host_rdata;
    logic           cnt_we, cnt_re;
    logic [AW-1:0]  cnt_raddr;
    logic [WW-1:0]  cnt_wdata, cnt_rdata;

    htat_pkg::class_t   cls;
    htat_pkg::add_ctl_t add_ctl;
    logic [CTW-1:0]     add_sum;

    logic accept;
    logic issue;
    logic hit;
    logic pass_end;
    logic table_is_full;

    assign accept   = in_valid && (state_reg == htat_pkg::ST_IDLE);
    assign in_stall = (state_reg != htat_pkg::ST_IDLE);

    // ---------------------------------------------------------------
    // Submodules
    // ---------------------------------------------------------------
    htat_subnet #(
        .LOCAL_SUBNETS (LOCAL_SUBNETS)
    ) u_subnet (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .src_ip    (src_reg),
        .dst_ip    (dst_reg),
        .cls       (cls)
    );

    // Host address per entry
    htat_ram #(
        .WIDTH (IPW),
        .DEPTH (TABLE_ENTRIES)
    ) u_host_ram (
        .clk   (clk),
        .we    (host_we),
        .waddr (host_waddr),
        .wdata (key_reg),
        .re    (host_re),
        .raddr (host_raddr),
        .rdata (host_rdata)
    );

    // Four 64-bit counters per entry, one word
    htat_ram #(
        .WIDTH (WW),
        .DEPTH (TABLE_ENTRIES)
    ) u_cnt_ram (
        .clk   (clk),
        .we    (cnt_we),
        .waddr (target_reg),
        .wdata (cnt_wdata),
        .re    (cnt_re),
        .raddr (cnt_raddr),
        .rdata (cnt_rdata)
    );

    assign add_ctl.lane  = lane_reg;
    assign add_ctl.fresh = fresh_reg;
    assign add_ctl.unacc = unacc_reg;

    htat_adder u_adder (
        .old_word     (cnt_rdata),
        .ctl          (add_ctl),
        .flow_packets (pk_reg),
        .flow_bytes   (by_reg),
        .sum          (add_sum)
    );

    assign cnt_wdata = {sum_reg[htat_pkg::LANE_UNAC_BYTE], sum_reg[htat_pkg::LANE_UNAC_PKT],
                        sum_reg[htat_pkg::LANE_ACCT_BYTE], sum_reg[htat_pkg::LANE_ACCT_PKT]};

    // Search: one address issued per cycle, compared when its data returns.
    assign issue         = (scan_reg < fill_count_reg);
    assign hit           = pend_reg && (host_rdata == key_reg);
    assign table_is_full = (fill_count_reg == CW'(TABLE_ENTRIES));

    // ---------------------------------------------------------------
    // Sequencer
    // ---------------------------------------------------------------
    always_comb
    begin
        state_next       = state_reg;
        fill_count_next  = fill_count_reg;
        scan_next        = scan_reg;
        pend_next        = 1'b0;
        pend_idx_next    = pend_idx_reg;
        target_next      = target_reg;
        key_next         = key_reg;
        fresh_next       = fresh_reg;
        unacc_next       = unacc_reg;
        second_next      = second_reg;
        lane_next        = lane_reg;
        full_next        = full_reg;
        cat_next         = cat_reg;
        entry_ok_next    = entry_ok_reg;

        out_valid_next   = out_valid_reg && out_stall;
        category_next    = category_reg;
        table_full_next  = table_full_reg;
        entry_valid_next = entry_valid_reg;
        entry_ip_next    = entry_ip_reg;
        entry_pk_next    = entry_pk_reg;
        entry_by_next    = entry_by_reg;
        entry_upk_next   = entry_upk_reg;
        entry_uby_next   = entry_uby_reg;

        host_we    = 1'b0;
        host_waddr = fill_count_reg[AW-1:0];
        host_re    = 1'b0;
        host_raddr = scan_reg[AW-1:0];
        cnt_we     = 1'b0;
        cnt_re     = 1'b0;
        cnt_raddr  = pend_idx_reg;
        pass_end   = 1'b0;

        unique case (state_reg)
            htat_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    full_next  = 1'b0;
                    cat_next   = '0;
                    state_next = (req_type == htat_pkg::REQ_READ) ? htat_pkg::ST_READ
                                                                  : htat_pkg::ST_CLASSIFY;
                end
            end

            htat_pkg::ST_CLASSIFY:
            begin
                cat_next = {cls.dst_local, cls.src_local};
                if (!cls.src_local && !cls.dst_local)
                begin
                    state_next = htat_pkg::ST_DONE;
                end
                else
                begin
                    // Source goes first when both are local.
                    key_next    = cls.src_local ? src_reg : dst_reg;
                    unacc_next  = cls.src_local && cls.dst_local;
                    second_next = cls.src_local && cls.dst_local;
                    scan_next   = '0;
                    state_next  = htat_pkg::ST_SCAN;
                end
            end

            htat_pkg::ST_SCAN:
            begin
                if (hit)
                begin
                    cnt_re      = 1'b1;
                    cnt_raddr   = pend_idx_reg;
                    target_next = pend_idx_reg;
                    fresh_next  = 1'b0;
                    lane_next   = '0;
                    state_next  = htat_pkg::ST_ADD;
                end
                else
                begin
                    host_re       = issue;
                    pend_next     = issue;
                    pend_idx_next = scan_reg[AW-1:0];
                    if (issue)
                    begin
                        scan_next = scan_reg + CW'(1);
                    end
                    else if (!pend_reg)
                    begin
                        // Miss: append, or drop this update when the table is full.
                        if (table_is_full)
                        begin
                            full_next = 1'b1;
                            pass_end  = 1'b1;
                        end
                        else
                        begin
                            host_we         = 1'b1;
                            target_next     = fill_count_reg[AW-1:0];
                            fresh_next      = 1'b1;
                            lane_next       = '0;
                            fill_count_next = fill_count_reg + CW'(1);
                            state_next      = htat_pkg::ST_ADD;
                        end
                    end
                end
            end

            htat_pkg::ST_ADD:
            begin
                lane_next = lane_reg + 2'd1;
                if (lane_reg == htat_pkg::LANE_UNAC_BYTE)
                begin
                    state_next = htat_pkg::ST_WRITE;
                end
            end

            htat_pkg::ST_WRITE:
            begin
                cnt_we   = 1'b1;
                pass_end = 1'b1;
            end

            htat_pkg::ST_READ:
            begin
                entry_ok_next = (CMPW'(idx_reg) < CMPW'(fill_count_reg));
                host_re       = 1'b1;
                host_raddr    = AW'(idx_reg);
                cnt_re        = 1'b1;
                cnt_raddr     = AW'(idx_reg);
                state_next    = htat_pkg::ST_DONE;
            end

            htat_pkg::ST_DONE:
            begin
                // Hold until the output register is free.
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next   = 1'b1;
                    category_next    = cat_reg;
                    table_full_next  = full_reg;
                    entry_valid_next = (req_reg == htat_pkg::REQ_READ) && entry_ok_reg;
                    if ((req_reg == htat_pkg::REQ_READ) && entry_ok_reg)
                    begin
                        entry_ip_next  = host_rdata;
                        entry_pk_next  = cnt_rdata[htat_pkg::LANE_ACCT_PKT * CTW +: CTW];
                        entry_by_next  = cnt_rdata[htat_pkg::LANE_ACCT_BYTE * CTW +: CTW];
                        entry_upk_next = cnt_rdata[htat_pkg::LANE_UNAC_PKT * CTW +: CTW];
                        entry_uby_next = cnt_rdata[htat_pkg::LANE_UNAC_BYTE * CTW +: CTW];
                    end
                    else
                    begin
                        entry_ip_next  = '0;
                        entry_pk_next  = '0;
                        entry_by_next  = '0;
                        entry_upk_next = '0;
                        entry_uby_next = '0;
                    end
                    state_next = htat_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = htat_pkg::ST_IDLE;
            end
        endcase

        // Advance to the destination host, or finish the transaction.
        if (pass_end)
        begin
            if (second_reg)
            begin
                key_next    = dst_reg;
                second_next = 1'b0;
                scan_next   = '0;
                state_next  = htat_pkg::ST_SCAN;
            end
            else
            begin
                state_next = htat_pkg::ST_DONE;
            end
        end
    end

    // ---------------------------------------------------------------
    // Registers
    // ---------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= htat_pkg::ST_IDLE;
            fill_count_reg <= '0;
            pend_reg       <= 1'b0;
            second_reg     <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            fill_count_reg <= fill_count_next;
            pend_reg       <= pend_next;
            second_reg     <= second_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        scan_reg        <= scan_next;
        pend_idx_reg    <= pend_idx_next;
        target_reg      <= target_next;
        key_reg         <= key_next;
        fresh_reg       <= fresh_next;
        unacc_reg       <= unacc_next;
        lane_reg        <= lane_next;
        full_reg        <= full_next;
        cat_reg         <= cat_next;
        entry_ok_reg    <= entry_ok_next;
        category_reg    <= category_next;
        table_full_reg  <= table_full_next;
        entry_valid_reg <= entry_valid_next;
        entry_ip_reg    <= entry_ip_next;
        entry_pk_reg    <= entry_pk_next;
        entry_by_reg    <= entry_by_next;
        entry_upk_reg   <= entry_upk_next;
        entry_uby_reg   <= entry_uby_next;
        if (accept)
        begin
            req_reg <= req_type;
            src_reg <= src_ip;
            dst_reg <= dst_ip;
            pk_reg  <= flow_packets;
            by_reg  <= flow_bytes;
            idx_reg <= read_index;
        end
        if (state_reg == htat_pkg::ST_ADD)
        begin
            sum_reg[lane_reg] <= add_sum;
        end
    end

    assign out_valid           = out_valid_reg;
    assign category            = category_reg;
    assign table_full          = table_full_reg;
    assign entry_valid         = entry_valid_reg;
    assign entry_ip            = entry_ip_reg;
    assign entry_packets       = entry_pk_reg;
    assign entry_bytes         = entry_by_reg;
    assign entry_unacc_packets = entry_upk_reg;
    assign entry_unacc_bytes   = entry_uby_reg;

`ifndef SYNTHESIS
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_count_reg <= CW'(TABLE_ENTRIES))
        else $error("fill count beyond table size");

    a_fill_step: assert property (@(posedge clk) disable iff (!rst_n)
        (fill_count_reg != $past(fill_count_reg)) |->
        (fill_count_reg == $past(fill_count_reg) + CW'(1)))
        else $error("fill count moved other than by one append");

    a_cnt_write: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_we |-> (CW'(target_reg) < fill_count_reg))
        else $error("counter write outside filled entries");

    a_read_resp: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && entry_valid_reg) |-> ((category_reg == '0) && !table_full_reg))
        else $error("read response carries record status");

    a_out_load: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == htat_pkg::ST_DONE))
        else $error("result loaded outside completion");
`endif

endmodule

`default_nettype wire
